// ===== hdl/aik_pkg.sv =====
// Package for the two-link arm inverse kinematics pipeline.
// Holds the CORDIC angle table, fixed constants and the shared stage type.
// No dependencies.
package aik_pkg;

  localparam int unsigned MaxStages = 24;
  localparam int unsigned AngW      = 34;  // 1/65536 degree, signed
  localparam int unsigned CorW      = 40;  // CORDIC x/y width, signed
  localparam int unsigned PosW      = 18;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned IdxW      = 2;

  localparam logic [IdxW-1:0] RegSlopeX = 2'd0;
  localparam logic [IdxW-1:0] RegSlopeY = 2'd1;
  localparam logic [IdxW-1:0] RegOffset = 2'd2;

  localparam logic signed [AngW-1:0] Deg90  = 34'sd5898240;
  localparam logic signed [AngW-1:0] Deg180 = 34'sd11796480;

  // One stage of a vectoring CORDIC lane.
  typedef struct packed {
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [AngW-1:0] ang;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_fine(input logic [4:0] i);
    logic signed [AngW-1:0] a;
    case (i)
      5'd0:  a = 34'sd2949120;
      5'd1:  a = 34'sd1740967;
      5'd2:  a = 34'sd919879;
      5'd3:  a = 34'sd466945;
      5'd4:  a = 34'sd234379;
      5'd5:  a = 34'sd117304;
      5'd6:  a = 34'sd58666;
      5'd7:  a = 34'sd29335;
      5'd8:  a = 34'sd14668;
      5'd9:  a = 34'sd7334;
      5'd10: a = 34'sd3667;
      5'd11: a = 34'sd1833;
      5'd12: a = 34'sd917;
      5'd13: a = 34'sd458;
      5'd14: a = 34'sd229;
      5'd15: a = 34'sd115;
      5'd16: a = 34'sd57;
      5'd17: a = 34'sd29;
      5'd18: a = 34'sd14;
      5'd19: a = 34'sd7;
      5'd20: a = 34'sd4;
      5'd21: a = 34'sd2;
      5'd22: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/aik_if.sv =====
// Valid/ready channel carrying one item per transfer.
// Payload width set by parameter; depends on nothing else.
interface aik_if #(parameter int unsigned W = 54) (input logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/aik_cordic_cell.sv =====
// One CORDIC vectoring micro-rotation cell with registered output.
// Uses aik_pkg for the stage type and angle table.
module aik_cordic_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  aik_pkg::cord_t c_i,
  output aik_pkg::cord_t c_o
);
  aik_pkg::cord_t n;
  logic signed [aik_pkg::CorW-1:0] xs, ys;
  always_comb begin
    xs = c_i.x >>> Idx;
    ys = c_i.y >>> Idx;
    n  = c_i;
    if (Idx < aik_pkg::MaxStages) begin
      if (c_i.y > 0) begin
        n.x = c_i.x + ys; n.y = c_i.y - xs;
        n.ang = c_i.ang + aik_pkg::atan_fine(5'(Idx));
      end else if (c_i.y < 0) begin
        n.x = c_i.x - ys; n.y = c_i.y + xs;
        n.ang = c_i.ang - aik_pkg::atan_fine(5'(Idx));
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) c_o <= n;
  end
endmodule

// ===== hdl/aik_sqrt_cell.sv =====
// One step of a restoring integer square root, two radicand bits per cell.
// Standalone; registered output with side payload passed along.
module aik_sqrt_cell #(
  parameter int unsigned W   = 64,
  parameter int unsigned Bit = 0,
  parameter int unsigned PW  = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  v_i,
  input  logic [W-1:0]  r_i,
  input  logic [PW-1:0] p_i,
  output logic [W-1:0]  v_o,
  output logic [W-1:0]  r_o,
  output logic [PW-1:0] p_o
);
  localparam logic [W-1:0] B = W'(1) << (2 * Bit);
  logic [W-1:0] vn, rn;
  always_comb begin
    if (v_i >= r_i + B) begin
      vn = v_i - (r_i + B);
      rn = (r_i >> 1) + B;
    end else begin
      vn = v_i;
      rn = r_i >> 1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o <= vn; r_o <= rn; p_o <= p_i;
    end
  end
endmodule

// ===== hdl/aik_div_cell.sv =====
// One restoring division step, one quotient bit per cell.
// Standalone; registered output with side payload passed along.
module aik_div_cell #(
  parameter int unsigned NW = 50,
  parameter int unsigned DW = 26,
  parameter int unsigned PW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] d_i,
  input  logic [PW-1:0] p_i,
  output logic [NW-1:0] n_o,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] d_o,
  output logic [PW-1:0] p_o
);
  logic [DW+1:0] t;
  always_comb t = {rem_i, n_i[NW-1]};
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (t >= {2'b0, d_i}) begin
        rem_o <= (DW+1)'(t - {2'b0, d_i});
        n_o   <= {n_i[NW-2:0], 1'b1};
      end else begin
        rem_o <= (DW+1)'(t);
        n_o   <= {n_i[NW-2:0], 1'b0};
      end
      d_o <= d_i; p_o <= p_i;
    end
  end
endmodule

// ===== hdl/arm_inverse_kinematics.sv =====
// Two-link arm inverse kinematics, pipelined as a row of fixed-point cells.
//
// Channels: in_if carries {target_z, target_y, target_x} (18 bits signed each,
// 1/256 mm); out_if carries {on_axis, out_of_reach, angle_elbow,
// angle_shoulder, angle_base}. Both use valid/ready; a transfer happens when
// both are high. Configuration: cfg_we_i writes cfg_data_i into register
// cfg_idx_i (0 slope x, 1 slope y, 2 tool offset); the user must write only while idle, the block does not enforce it.
//
// Throughput: one item per cycle while the row is not held. The whole pipeline
// advances as one row of cells; each cell is a square-root step, a divide step
// or a CORDIC micro-rotation. A result is offered once its input has passed the
// chain sqrt -> divide -> sqrt -> sqrt -> CORDIC and the final sum and clamp
// registers. When out_if.valid is high and out_if.ready low the whole row holds
// (in_if.ready follows the output register being free or taken), so nothing is
// lost or repeated. Reset clears the valid bits of every stage and the
// configuration registers to zero.
module arm_inverse_kinematics #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  aik_if.sink         in_if,
  aik_if.source       out_if
);
  localparam int unsigned NS = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  // stage plan
  localparam int unsigned SQ1 = 26;   // r_fine root: radicand 52 bits
  localparam int unsigned DV  = 42;   // pull quotient bits
  localparam int unsigned SQ2 = 19;   // s, d roots: radicand 38 bits
  localparam int unsigned SQ3 = 19;   // acos leg root
  localparam int unsigned TOT = 2 + SQ1 + 1 + DV + 2 + SQ2 + 1 + SQ3 + 1 + NS + 2;

  logic signed [15:0] sx_q, sy_q;
  logic [15:0]        off_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0; sy_q <= '0; off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aik_pkg::RegSlopeX: sx_q  <= cfg_data_i;
        aik_pkg::RegSlopeY: sy_q  <= cfg_data_i;
        aik_pkg::RegOffset: off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: whole row moves unless the output register is held.
  logic adv;
  logic [TOT-1:0] vld_q;
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[TOT-2:0], in_if.valid};
  end

  // ---------------- stage A: leveling products, squares -----------------
  logic signed [17:0] x0, y0, z0;
  assign x0 = in_if.data[17:0];
  assign y0 = in_if.data[35:18];
  assign z0 = in_if.data[53:36];
  logic signed [34:0] px_q, py_q;
  logic signed [17:0] xa_q, ya_q, za_q;
  logic [35:0]        x2_q, y2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q <= 35'(sx_q * x0);
      py_q <= 35'(sy_q * (19'(y0) - 19'sd51200));
      x2_q <= 36'(x0 * x0);
      y2_q <= 36'(y0 * y0);
      xa_q <= x0; ya_q <= y0; za_q <= z0;
    end
  end
  // stage B: z level, radius radicand
  localparam int unsigned PW = 18 + 18 + 20 + 1;  // x, y, z, axis
  logic [51:0]   rad1_q;
  logic [PW-1:0] pb_q;
  always_ff @(posedge clk_i) begin
    logic signed [36:0] c;
    if (adv) begin
      c      = 37'(px_q) + 37'(py_q) + 37'sd16384;
      rad1_q <= {(x2_q + y2_q), 16'b0};
      pb_q   <= {(xa_q == 0 && ya_q == 0), 20'(za_q) + 20'(c >>> 15), ya_q, xa_q};
    end
  end

  // r_fine = isqrt((x^2+y^2)<<16); radicand < 2^52
  logic [51:0] sv [SQ1+1];
  logic [51:0] sr [SQ1+1];
  logic [PW-1:0] sp [SQ1+1];
  assign sv[0] = rad1_q; assign sr[0] = '0; assign sp[0] = pb_q;
  for (genvar k = 0; k < SQ1; k++) begin : g_sq1
    aik_sqrt_cell #(.W(52), .Bit(SQ1-1-k), .PW(PW)) u_c (
      .clk_i, .en_i(adv), .v_i(sv[k]), .r_i(sr[k]), .p_i(sp[k]),
      .v_o(sv[k+1]), .r_o(sr[k+1]), .p_o(sp[k+1]));
  end

  // Numerators: |c|*off*256 + r/2 for x and y, share divisor r.
  localparam int unsigned NW = DV;
  localparam int unsigned DW = 26;
  logic [NW-1:0] nx_q, ny_q;
  logic [DW-1:0] dr_q;
  logic [PW-1:0] pc_q;
  always_ff @(posedge clk_i) begin
    logic [17:0] mx, my;
    logic [25:0] r;
    if (adv) begin
      r  = sr[SQ1][25:0];
      mx = sp[SQ1][17] ? 18'(-sp[SQ1][17:0]) : sp[SQ1][17:0];
      my = sp[SQ1][35] ? 18'(-sp[SQ1][35:18]) : sp[SQ1][35:18];
      nx_q <= NW'({mx, 8'b0} * off_q) + NW'(r >> 1);
      ny_q <= NW'({my, 8'b0} * off_q) + NW'(r >> 1);
      dr_q <= (r == 0) ? DW'(1) : r;
      pc_q <= sp[SQ1];
    end
  end
  logic [NW-1:0] qxn [DV+1], qyn [DV+1];
  logic [DW:0]   rx [DV+1], ry [DV+1];
  logic [DW-1:0] dx [DV+1], dy [DV+1];
  logic [PW-1:0] pq [DV+1];
  logic          unused_p [DV+1];
  assign qxn[0] = nx_q; assign qyn[0] = ny_q; assign rx[0] = '0; assign ry[0] = '0;
  assign dx[0] = dr_q; assign dy[0] = dr_q; assign pq[0] = pc_q; assign unused_p[0] = 1'b0;
  for (genvar k = 0; k < DV; k++) begin : g_div
    aik_div_cell #(.NW(NW), .DW(DW), .PW(PW)) u_x (
      .clk_i, .en_i(adv), .n_i(qxn[k]), .rem_i(rx[k]), .d_i(dx[k]), .p_i(pq[k]),
      .n_o(qxn[k+1]), .rem_o(rx[k+1]), .d_o(dx[k+1]), .p_o(pq[k+1]));
    aik_div_cell #(.NW(NW), .DW(DW), .PW(1)) u_y (
      .clk_i, .en_i(adv), .n_i(qyn[k]), .rem_i(ry[k]), .d_i(dy[k]),
      .p_i(unused_p[k]), .n_o(qyn[k+1]), .rem_o(ry[k+1]), .d_o(dy[k+1]),
      .p_o(unused_p[k+1]));
  end

  // Apply pull, floor y, then squares.
  logic signed [19:0] xp_q, yp_q, zp_q;
  logic               ax_q;
  always_ff @(posedge clk_i) begin
    logic signed [19:0] xc, yc;
    logic signed [35:0] qx, qy;
    if (adv) begin
      xc = 20'(signed'(pq[DV][17:0]));
      yc = 20'(signed'(pq[DV][35:18]));
      qx = 36'(qxn[DV]); qy = 36'(qyn[DV]);
      if (!pq[DV][56]) begin
        xc = xc[19] ? 20'(36'(xc) + qx) : 20'(36'(xc) - qx);
        yc = yc[19] ? 20'(36'(yc) + qy) : 20'(36'(yc) - qy);
      end
      if (yc < 20'sd3) yc = 20'sd3;
      xp_q <= xc; yp_q <= yc; zp_q <= pq[DV][55:36]; ax_q <= pq[DV][56];
    end
  end
  logic [39:0] s2_q, z2_q;
  logic signed [19:0] xs_q, ys_q, zs_q;
  logic ax2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q <= 40'(xp_q * xp_q) + 40'(yp_q * yp_q);
      z2_q <= 40'(zp_q * zp_q);
      xs_q <= xp_q; ys_q <= yp_q; zs_q <= zp_q; ax2_q <= ax_q;
    end
  end
  // dual root of s2 and s2+z2; side payload carries x, y, z, axis, sum
  localparam int unsigned P3 = 20*3 + 1 + 41;
  logic [37:0] av [SQ2+1], ar [SQ2+1], bv [SQ2+1], br [SQ2+1];
  logic [P3-1:0] ap [SQ2+1];
  logic          bp [SQ2+1];
  logic [40:0]   sum_w;
  assign sum_w = 41'(s2_q) + 41'(z2_q);
  assign av[0] = 38'(s2_q); assign ar[0] = '0;
  assign bv[0] = 38'(sum_w); assign br[0] = '0; assign bp[0] = 1'b0;
  assign ap[0] = {sum_w, ax2_q, zs_q, ys_q, xs_q};
  for (genvar k = 0; k < SQ2; k++) begin : g_sq2
    aik_sqrt_cell #(.W(38), .Bit(SQ2-1-k), .PW(P3)) u_a (
      .clk_i, .en_i(adv), .v_i(av[k]), .r_i(ar[k]), .p_i(ap[k]),
      .v_o(av[k+1]), .r_o(ar[k+1]), .p_o(ap[k+1]));
    aik_sqrt_cell #(.W(38), .Bit(SQ2-1-k), .PW(1)) u_b (
      .clk_i, .en_i(adv), .v_i(bv[k]), .r_i(br[k]), .p_i(bp[k]),
      .v_o(bv[k+1]), .r_o(br[k+1]), .p_o(bp[k+1]));
  end
  // leg radicand L^2 - sum
  localparam logic [40:0] Lsq = 41'd5898240000;
  localparam int unsigned P4 = 20*3 + 1 + 1 + 19 + 19;
  logic [37:0] lv_q;
  logic [P4-1:0] p4_q;
  always_ff @(posedge clk_i) begin
    logic far;
    if (adv) begin
      far  = ap[SQ2][101:61] > Lsq;
      lv_q <= far ? '0 : 38'(Lsq - ap[SQ2][101:61]);
      p4_q <= {br[SQ2][18:0], ar[SQ2][18:0], far, ap[SQ2][60:0]};
    end
  end
  logic [37:0] cv [SQ3+1], cr [SQ3+1];
  logic [P4-1:0] cp [SQ3+1];
  assign cv[0] = lv_q; assign cr[0] = '0; assign cp[0] = p4_q;
  for (genvar k = 0; k < SQ3; k++) begin : g_sq3
    aik_sqrt_cell #(.W(38), .Bit(SQ3-1-k), .PW(P4)) u_c (
      .clk_i, .en_i(adv), .v_i(cv[k]), .r_i(cr[k]), .p_i(cp[k]),
      .v_o(cv[k+1]), .r_o(cr[k+1]), .p_o(cp[k+1]));
  end

  // CORDIC prerotation for three lanes: base (y,x), thb2 (z,s), thb1 (leg,d)
  function automatic aik_pkg::cord_t pre(input logic signed [20:0] y,
                                         input logic signed [20:0] x);
    aik_pkg::cord_t c;
    logic signed [aik_pkg::CorW-1:0] xx, yy;
    xx = aik_pkg::CorW'(x) <<< 8;
    yy = aik_pkg::CorW'(y) <<< 8;
    c.ang = '0; c.x = xx; c.y = yy;
    if (xx < 0) begin
      if (yy >= 0) begin
        c.x = yy; c.y = -xx; c.ang = aik_pkg::Deg90;
      end else begin
        c.x = -yy; c.y = xx; c.ang = -aik_pkg::Deg90;
      end
    end
    return c;
  endfunction
  localparam int unsigned P5 = 3;  // xzero, far, axis
  aik_pkg::cord_t l0 [NS+1], l1 [NS+1], l2 [NS+1];
  logic [P5-1:0] fp [NS+1];
  aik_pkg::cord_t l0_q, l1_q, l2_q;
  logic [P5-1:0] f_q;
  always_ff @(posedge clk_i) begin
    logic [P4-1:0] p;
    if (adv) begin
      p    = cp[SQ3];
      l0_q <= pre(21'(signed'(p[39:20])), 21'(signed'(p[19:0])));
      l1_q <= pre(21'(signed'(p[59:40])), 21'({1'b0, p[80:62]}));
      l2_q <= pre(21'({1'b0, cr[SQ3][18:0]}), 21'({1'b0, p[99:81]}));
      f_q  <= {p[19:0] == 0, p[61], p[60]};
    end
  end
  assign l0[0] = l0_q; assign l1[0] = l1_q; assign l2[0] = l2_q; assign fp[0] = f_q;
  for (genvar k = 0; k < NS; k++) begin : g_cor
    aik_cordic_cell #(.Idx(k)) u_0 (.clk_i, .en_i(adv), .c_i(l0[k]), .c_o(l0[k+1]));
    aik_cordic_cell #(.Idx(k)) u_1 (.clk_i, .en_i(adv), .c_i(l1[k]), .c_o(l1[k+1]));
    aik_cordic_cell #(.Idx(k)) u_2 (.clk_i, .en_i(adv), .c_i(l2[k]), .c_o(l2[k+1]));
    always_ff @(posedge clk_i) begin
      if (adv) fp[k+1] <= fp[k];
    end
  end

  // Final: sums, rounding, clamping.
  function automatic logic signed [25:0] rnd(input logic signed [35:0] f);
    logic signed [35:0] v;
    v = (f + 36'sd256) >>> 9;
    return 26'(v);
  endfunction
  logic signed [35:0] fb_q, fs_q, fe_q;
  logic [P5-1:0]      ff_q;
  always_ff @(posedge clk_i) begin
    logic signed [35:0] t1;
    if (adv) begin
      t1   = fp[NS][1] ? '0 : 36'(l2[NS].ang);
      fb_q <= 36'(aik_pkg::Deg180) - 36'(l0[NS].ang);
      fs_q <= t1 + 36'(l1[NS].ang);
      fe_q <= 36'(aik_pkg::Deg90) + 36'(l1[NS].ang) - t1;
      ff_q <= fp[NS];
    end
  end
  logic [14:0] ob_q;
  logic signed [15:0] os_q, oe_q;
  logic [1:0] of_q;
  logic ov_q;
  always_ff @(posedge clk_i) begin
    logic signed [25:0] b, s, e;
    if (adv) begin
      b = rnd(fb_q); s = rnd(fs_q); e = rnd(fe_q);
      if (b < 0) b = '0; if (b > 26'sd23040) b = 26'sd23040;
      if (s < -26'sd11520) s = -26'sd11520; if (s > 26'sd23040) s = 26'sd23040;
      if (e < -26'sd11520) e = -26'sd11520; if (e > 26'sd23040) e = 26'sd23040;
      ob_q <= ff_q[2] ? 15'd11520 : b[14:0];
      os_q <= s[15:0]; oe_q <= e[15:0];
      of_q <= ff_q[1:0];
    end
  end
  assign ov_q = vld_q[TOT-1];
  assign out_if.valid = ov_q;
  assign out_if.data  = {of_q[0], of_q[1], oe_q, os_q, ob_q};
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for arm_inverse_kinematics: random and corner target points,
// predicted joint angles compared transfer by transfer. Uses aik_pkg and aik_if.
module tb_top;

  localparam int unsigned Stages = 16;
  localparam int unsigned LatCycles = 400;

  typedef struct packed {
    logic        axis;
    logic        far;
    logic [15:0] elbow;
    logic [15:0] shoulder;
    logic [14:0] base;
  } joint_t;

  typedef struct packed {
    logic signed [17:0] z;
    logic signed [17:0] y;
    logic signed [17:0] x;
  } target_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = aik_pkg::RegSlopeX;
  logic [15:0] cfg_data_i = '0;

  aik_if #(.W(54)) in_if (.clk_i(clk_i));
  aik_if #(.W(49)) out_if (.clk_i(clk_i));

  arm_inverse_kinematics #(.CORDIC_STAGES(Stages)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_if.sink), .out_if(out_if.source)
  );

  // Bench copy of the configuration, updated with each register write.
  logic signed [15:0] slope_x = '0;
  logic signed [15:0] slope_y = '0;
  logic [15:0] offset = '0;

  target_t pending_targets[$];
  joint_t  expected_joints[$];
  target_t cur_target;
  bit      no_idle = 1'b0;
  int      mismatches = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Vectoring atan2 in 1/65536 degree, same stage table as the hardware.
  function automatic longint vec_atan2(longint yi, longint xi);
    longint ang = 0;
    longint x = xi * 256;
    longint y = yi * 256;
    longint t, xs, ys;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; ang = -90 * 65536;
      end
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; ang += longint'(aik_pkg::atan_fine(i[4:0]));
      end else if (y < 0) begin
        x -= ys; y += xs; ang -= longint'(aik_pkg::atan_fine(i[4:0]));
      end
    end
    return ang;
  endfunction

  function automatic longint round_clamp(longint fine, longint lo, longint hi);
    longint v = (fine + 256) >>> 9;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  // Move one coordinate toward the axis by the tool offset, rounded half away.
  function automatic longint radial_pull(longint c, longint unsigned r_fine);
    longint unsigned mag = (c < 0) ? longint'(-c) : longint'(c);
    longint unsigned q = (mag * longint'(offset) * 256 + r_fine / 2) / r_fine;
    return (c < 0) ? c + longint'(q) : c - longint'(q);
  endfunction

  function automatic joint_t solve_joints(target_t t);
    longint x = t.x;
    longint y = t.y;
    longint z = t.z;
    longint base, thb1, thb2, sh, el;
    longint unsigned r_fine, s2, sum, lsq, s, d;
    joint_t j;
    bit axis = (x == 0 && y == 0);
    bit far;
    thb1 = 0;
    z += (longint'(slope_x) * x + longint'(slope_y) * (y - 51200) + 16384) >>> 15;
    if (!axis) begin
      r_fine = int_sqrt(longint'(x * x + y * y) << 16);
      x = radial_pull(x, r_fine);
      y = radial_pull(y, r_fine);
    end
    if (y < 3) y = 3;
    if (x == 0) base = 11520;
    else base = round_clamp(180 * 65536 - vec_atan2(y, x), 0, 23040);
    s2 = x * x + y * y;
    sum = s2 + z * z;
    lsq = 64'd76800 * 64'd76800;
    s = int_sqrt(s2);
    d = int_sqrt(sum);
    far = sum > lsq;
    thb2 = vec_atan2(z, longint'(s));
    if (!far) thb1 = vec_atan2(longint'(int_sqrt(lsq - sum)), longint'(d));
    sh = round_clamp(thb1 + thb2, -11520, 23040);
    el = round_clamp(90 * 65536 + thb2 - thb1, -11520, 23040);
    j.base = base[14:0];
    j.shoulder = sh[15:0];
    j.elbow = el[15:0];
    j.far = far;
    j.axis = axis;
    return j;
  endfunction

  // Driver: on each transfer store the prediction, then load the next point.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) expected_joints.push_back(solve_joints(cur_target));
      if (pending_targets.size() > 0 && (no_idle || $urandom_range(99) >= 21)) begin
        cur_target = pending_targets.pop_front();
        in_if.data <= cur_target;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: stall at random, check every result transfer against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    joint_t got, want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_joints.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_joints.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      out_if.ready <= no_idle || ($urandom_range(99) >= 21);
    end
  end

  function automatic void add_target(int x, int y, int z);
    target_t t;
    t.x = x[17:0];
    t.y = y[17:0];
    t.z = z[17:0];
    pending_targets.push_back(t);
  endfunction

  // Mostly points within +/-60000 in x and y and +/-40000 in z, some full-range noise.
  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) != 0)
        add_target($urandom_range(120000) - 60000, $urandom_range(120000) - 60000,
                   $urandom_range(80000) - 40000);
      else
        add_target($urandom_range(262143) - 131072, $urandom_range(262143) - 131072,
                   $urandom_range(262143) - 131072);
    end
  endtask

  // Hold stimulus until the pipeline has drained.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_targets.size() != 0 || in_if.valid || expected_joints.size() != 0);
  endtask

  task automatic write_regs(logic [15:0] sx, logic [15:0] sy, logic [15:0] off);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= aik_pkg::RegSlopeX; cfg_data_i <= sx;
    slope_x = sx;
    @(posedge clk_i);
    cfg_idx_i <= aik_pkg::RegSlopeY; cfg_data_i <= sy;
    slope_y = sy;
    @(posedge clk_i);
    cfg_idx_i <= aik_pkg::RegOffset; cfg_data_i <= off;
    offset = off;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Corners: field extremes, on axis, x zero, y floor, reach boundary.
    add_target(131071, 131071, 131071);
    add_target(-131072, -131072, -131072);
    add_target(0, 0, 0);
    add_target(0, 0, 20000);
    add_target(0, 30000, -5000);
    add_target(-40000, 0, 1000);
    add_target(40000, -1, 0);
    add_target(25000, 1, 5000);
    add_target(76800, 0, 0);
    add_target(0, 76797, 0);
    add_target(50000, 50000, 30000);
    add_target(-50000, 20000, -60000);
    add_target(1, 1, -131072);
    add_target(-1, 2, 131071);
    write_regs(16'h7fff, 16'h8000, 16'hffff);
    add_target(3000, 4000, 0);
    add_target(0, 0, 10000);
    add_target(-60000, 60000, 20000);
    add_target(131071, -131072, 0);
    add_random(90);
    write_regs(16'h8000, 16'h7fff, 16'd0);
    add_random(90);
    no_idle = 1'b1;
    write_regs(16'd300, -16'sd200, 16'd12800);
    add_random(100);
    wait_drained();
    no_idle = 1'b0;
    write_regs(16'($urandom), 16'($urandom), 16'($urandom));
    add_random(100);
    write_regs(16'd0, 16'd0, 16'($urandom_range(2560)));
    add_random(100);

    wait_drained();
    repeat (LatCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_joints.size() == 0)
      $display("PASS arm_inverse_kinematics");
    else
      $display("FAIL arm_inverse_kinematics");
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL arm_inverse_kinematics");
    $finish;
  end

endmodule
